@@ hdl/sdspi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SD SPI single block package
// Shared constants, command codes, the function and status types and the sequencer phase type.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned DEFAULT_BLOCK_BYTES = 512;

  localparam logic [7:0] FILL_BYTE  = 8'hFF;
  localparam logic [7:0] DATA_TOKEN = 8'hFE;
  localparam logic [7:0] CMD17_READ  = 8'h51;
  localparam logic [7:0] CMD24_WRITE = 8'h58;
  localparam logic [7:0] DRESP_MASK  = 8'h1F;
  localparam logic [7:0] DRESP_OK    = 8'h05;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_REPLY = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_R1_ERR   = 2'd1,
    STATUS_DATA_REJ = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_READY = 4'd1,
    PH_CMD   = 4'd2,
    PH_R1    = 4'd3,
    PH_GAP   = 4'd4,
    PH_WDATA = 4'd5,
    PH_DRESP = 4'd6,
    PH_TOKEN = 4'd7,
    PH_RDATA = 4'd8,
    PH_CRC   = 4'd9,
    PH_FINAL = 4'd10
  } phase_e;

endpackage : sdspi_pkg
`default_nettype wire

@@ hdl/sdspi_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdspi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : sdspi_ram
`default_nettype wire

@@ hdl/sd_spi_single_block_rw_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SD card SPI-mode single block read/write sequencer
// Issues CMD17/CMD24 for one block and steps through the card exchange,
// answering each card reply word with the next word to send.
// ----------------------------------------------------------------------------
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+----------------------------------------
//  in       | in_valid_i / in_stall_o | func, block_number, load_index, byte_in
//  out      | out_valid_o/ out_stall_i| send/read/done/status/busy fields
//  config   | cfg_we_i                | cfg_wdata_i (byte addressing)
//
// Every accepted input word yields one registered output word in the cycle after.
// A new word is taken each cycle unless the output register is full and
// stalled. The write buffer is read at the next byte count, so the data
// byte is ready when the card reply arrives.
// Reset returns the sequencer to idle; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module sd_spi_single_block_rw_unit #(
  parameter int unsigned BLOCK_BYTES = sdspi_pkg::DEFAULT_BLOCK_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [31:0] block_number_i,
  input  wire logic [8:0]  load_index_i,
  input  wire logic [7:0]  byte_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             send_valid_o,
  output logic [7:0]       tx_byte_o,
  output logic             read_valid_o,
  output logic [7:0]       read_byte_o,
  output logic [8:0]       read_index_o,
  output logic             done_res_o,
  output logic [1:0]       status_o,
  output logic [7:0]       error_reply_o,
  output logic             busy_res_o
);
  import sdspi_pkg::*;

  localparam int unsigned AW    = $clog2(BLOCK_BYTES);
  localparam int unsigned CNT_W = $clog2(BLOCK_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_CMD_END = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_BLOCK   = CNT_W'(BLOCK_BYTES);

  logic            byte_addr_q;
  phase_e          phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]     cmd_addr_q, cmd_addr_d;
  logic            is_write_q, is_write_d;

  logic            accept;
  logic            busy;
  func_e           func;
  logic [7:0]      ram_rdata;
  logic            ram_we;
  logic [7:0]      cmd_byte;
  logic [CNT_W-1:0] cnt_inc;

  logic            sv, rv, dn;
  logic [7:0]      sb, rb, er;
  logic [8:0]      ri;
  status_e         st;

  assign func       = func_e'(func_i);
  assign in_stall_o = out_valid_o & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign busy       = (phase_q != PH_IDLE);
  assign cnt_inc    = cnt_q + CNT_W'(1);

  // Load index is compared at full width so that small blocks drop stray loads.
  assign ram_we = accept && (func == FUNC_LOAD) && !busy &&
                  ({4'd0, load_index_i} < 13'(BLOCK_BYTES));

  sdspi_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_BYTES)
  ) u_wbuf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(load_index_i)),
    .wdata_i (byte_in_i),
    .raddr_i (cnt_d[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (cnt_q[2:0])
      3'd0:    cmd_byte = is_write_q ? CMD24_WRITE : CMD17_READ;
      3'd1:    cmd_byte = cmd_addr_q[31:24];
      3'd2:    cmd_byte = cmd_addr_q[23:16];
      3'd3:    cmd_byte = cmd_addr_q[15:8];
      3'd4:    cmd_byte = cmd_addr_q[7:0];
      default: cmd_byte = FILL_BYTE;
    endcase
  end

  // Next state.
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    cmd_addr_d = cmd_addr_q;
    is_write_d = is_write_q;
    if (accept) begin
      unique case (func)
        FUNC_LOAD: ;
        FUNC_READ, FUNC_WRITE: begin
          if (!busy) begin
            is_write_d = (func == FUNC_WRITE);
            cmd_addr_d = byte_addr_q ? 32'(block_number_i * 32'(BLOCK_BYTES))
                                     : block_number_i;
            cnt_d      = '0;
            phase_d    = PH_READY;
          end
        end
        FUNC_REPLY: begin
          unique case (phase_q)
            PH_READY: begin
              if (byte_in_i == FILL_BYTE) begin
                cnt_d   = CNT_W'(1);
                phase_d = PH_CMD;
              end
            end
            PH_CMD: begin
              if (cnt_q < CNT_CMD_END) cnt_d = cnt_inc;
              else phase_d = PH_R1;
            end
            PH_R1: begin
              if (byte_in_i != FILL_BYTE) begin
                if (byte_in_i != 8'd0) phase_d = PH_IDLE;
                else phase_d = is_write_q ? PH_GAP : PH_TOKEN;
              end
            end
            PH_GAP: begin
              cnt_d   = '0;
              phase_d = PH_WDATA;
            end
            PH_WDATA: begin
              if (cnt_q < CNT_BLOCK) cnt_d = cnt_inc;
              else phase_d = PH_DRESP;
            end
            PH_DRESP: begin
              if (byte_in_i != FILL_BYTE) begin
                if ((byte_in_i & DRESP_MASK) != DRESP_OK) phase_d = PH_IDLE;
                else phase_d = PH_FINAL;
              end
            end
            PH_TOKEN: begin
              if (byte_in_i == DATA_TOKEN) begin
                cnt_d   = '0;
                phase_d = PH_RDATA;
              end
            end
            PH_RDATA: begin
              if (cnt_inc >= CNT_BLOCK) begin
                cnt_d   = '0;
                phase_d = PH_CRC;
              end else begin
                cnt_d = cnt_inc;
              end
            end
            PH_CRC: begin
              if (cnt_q == '0) begin
                cnt_d = CNT_W'(1);
              end else begin
                cnt_d   = '0;
                phase_d = PH_FINAL;
              end
            end
            PH_FINAL: begin
              if (byte_in_i == FILL_BYTE) phase_d = PH_IDLE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Result word.
  always_comb begin
    sv = 1'b0;
    sb = 8'd0;
    rv = 1'b0;
    rb = 8'd0;
    ri = 9'd0;
    dn = 1'b0;
    st = STATUS_OK;
    er = 8'd0;
    unique case (func)
      FUNC_LOAD: ;
      FUNC_READ, FUNC_WRITE: begin
        if (!busy) begin
          sv = 1'b1;
          sb = FILL_BYTE;
        end
      end
      FUNC_REPLY: begin
        sv = 1'b1;
        sb = FILL_BYTE;
        unique case (phase_q)
          PH_READY: begin
            if (byte_in_i == FILL_BYTE) sb = cmd_byte;
          end
          PH_CMD: begin
            if (cnt_q < CNT_CMD_END) sb = cmd_byte;
          end
          PH_R1: begin
            if (byte_in_i != FILL_BYTE && byte_in_i != 8'd0) begin
              sv = 1'b0;
              sb = 8'd0;
              dn = 1'b1;
              st = STATUS_R1_ERR;
              er = byte_in_i;
            end
          end
          PH_GAP: sb = DATA_TOKEN;
          PH_WDATA: begin
            if (cnt_q < CNT_BLOCK) sb = ram_rdata;
          end
          PH_DRESP: begin
            if (byte_in_i != FILL_BYTE && (byte_in_i & DRESP_MASK) != DRESP_OK) begin
              sv = 1'b0;
              sb = 8'd0;
              dn = 1'b1;
              st = STATUS_DATA_REJ;
              er = byte_in_i;
            end
          end
          PH_RDATA: begin
            rv = 1'b1;
            rb = byte_in_i;
            ri = 9'(cnt_q);
          end
          PH_FINAL: begin
            if (byte_in_i == FILL_BYTE) begin
              sv = 1'b0;
              sb = 8'd0;
              dn = 1'b1;
            end
          end
          PH_TOKEN, PH_CRC: ;
          default: begin
            sv = 1'b0;
            sb = 8'd0;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_addr_q <= 1'b0;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      cmd_addr_q  <= '0;
      is_write_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) byte_addr_q <= cfg_wdata_i;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      cmd_addr_q <= cmd_addr_d;
      is_write_q <= is_write_d;
      if (accept) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      send_valid_o  <= sv;
      tx_byte_o     <= sb;
      read_valid_o  <= rv;
      read_byte_o   <= rb;
      read_index_o  <= ri;
      done_res_o    <= dn;
      status_o      <= st;
      error_reply_o <= er;
      busy_res_o    <= (phase_d != PH_IDLE);
    end
  end

endmodule : sd_spi_single_block_rw_unit
`default_nettype wire

@@ hdl/sdspi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SD SPI single block checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sdspi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        send_valid_o,
  input wire logic [7:0]  tx_byte_o,
  input wire logic        read_valid_o,
  input wire logic        done_res_o,
  input wire logic [1:0]  status_o,
  input wire logic        busy_res_o
);
  import sdspi_pkg::*;

  // A held output word stays presented.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // The input side only stalls when the output register is full.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

  // The closing word sends nothing and leaves the block idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !send_valid_o)
    else $error("done word still busy or sending");

  // An error status is only reported on the closing word.
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> done_res_o)
    else $error("error status without done");

  // While data bytes are received the block clocks fill bytes out.
  a_read_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> busy_res_o && send_valid_o && (tx_byte_o == FILL_BYTE))
    else $error("read byte without fill byte or outside operation");

endmodule : sdspi_checker

bind sd_spi_single_block_rw_unit sdspi_checker u_sdspi_checker (.*);
`default_nettype wire

@@ tb/sd_spi_block_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI single block sequencer checker
// Watches the input, output and config ports of the sequencer, steps its own
// copy of the card exchange for every accepted input word and compares each
// accepted output word, field by field, with the oldest predicted word.
// ----------------------------------------------------------------------------
module sd_spi_block_checker #(
  parameter int unsigned BLOCK_BYTES = sdspi_pkg::DEFAULT_BLOCK_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [31:0] block_number_i,
  input  logic [8:0]  load_index_i,
  input  logic [7:0]  byte_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        send_valid_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        read_valid_i,
  input  logic [7:0]  read_byte_i,
  input  logic [8:0]  read_index_i,
  input  logic        done_res_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  error_reply_i,
  input  logic        busy_res_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import sdspi_pkg::*;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [8:0] read_index;
    logic       done;
    status_e    status;
    logic [7:0] error_reply;
    logic       busy;
  } card_step_t;

  card_step_t  expected_steps[$];
  phase_e      phase_q;
  int unsigned count_q;
  logic [31:0] address_q;
  logic        is_write_q;
  logic        byte_addr_q;
  logic [7:0]  write_buf [BLOCK_BYTES];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic logic [7:0] command_byte(int unsigned k);
    case (k)
      0: return is_write_q ? CMD24_WRITE : CMD17_READ;
      1: return address_q[31:24];
      2: return address_q[23:16];
      3: return address_q[15:8];
      4: return address_q[7:0];
      default: return FILL_BYTE;
    endcase
  endfunction

  // Advances the tracked exchange by one input word and returns the output
  // word the sequencer must produce for it.
  function automatic card_step_t advance_sequencer(func_e f, logic [31:0] blk,
                                                   logic [8:0] idx, logic [7:0] b);
    card_step_t r;
    logic       was_busy;
    r = '0;
    was_busy = (phase_q != PH_IDLE);
    case (f)
      FUNC_LOAD: begin
        if (!was_busy && idx < BLOCK_BYTES) write_buf[idx] = b;
      end
      FUNC_READ, FUNC_WRITE: begin
        if (!was_busy) begin
          is_write_q   = (f == FUNC_WRITE);
          address_q    = byte_addr_q ? blk * BLOCK_BYTES : blk;
          count_q      = 0;
          phase_q      = PH_READY;
          r.send_valid = 1'b1;
          r.tx_byte    = FILL_BYTE;
        end
      end
      default: begin
        if (was_busy) begin
          r.send_valid = 1'b1;
          r.tx_byte    = FILL_BYTE;
        end
        case (phase_q)
          PH_READY: begin
            if (b == FILL_BYTE) begin
              r.tx_byte = command_byte(0);
              count_q   = 1;
              phase_q   = PH_CMD;
            end
          end
          PH_CMD: begin
            if (count_q < 6) begin
              r.tx_byte = command_byte(count_q);
              count_q   = count_q + 1;
            end else begin
              phase_q = PH_R1;
            end
          end
          PH_R1: begin
            if (b != FILL_BYTE) begin
              if (b != 8'h00) begin
                r.send_valid  = 1'b0;
                r.tx_byte     = '0;
                r.done        = 1'b1;
                r.status      = STATUS_R1_ERR;
                r.error_reply = b;
                phase_q       = PH_IDLE;
              end else begin
                phase_q = is_write_q ? PH_GAP : PH_TOKEN;
              end
            end
          end
          PH_GAP: begin
            r.tx_byte = DATA_TOKEN;
            count_q   = 0;
            phase_q   = PH_WDATA;
          end
          PH_WDATA: begin
            if (count_q < BLOCK_BYTES) begin
              r.tx_byte = write_buf[count_q];
              count_q   = count_q + 1;
            end else begin
              phase_q = PH_DRESP;
            end
          end
          PH_DRESP: begin
            if (b != FILL_BYTE) begin
              if ((b & DRESP_MASK) != DRESP_OK) begin
                r.send_valid  = 1'b0;
                r.tx_byte     = '0;
                r.done        = 1'b1;
                r.status      = STATUS_DATA_REJ;
                r.error_reply = b;
                phase_q       = PH_IDLE;
              end else begin
                phase_q = PH_FINAL;
              end
            end
          end
          PH_TOKEN: begin
            if (b == DATA_TOKEN) begin
              count_q = 0;
              phase_q = PH_RDATA;
            end
          end
          PH_RDATA: begin
            r.read_valid = 1'b1;
            r.read_byte  = b;
            r.read_index = count_q[8:0];
            count_q      = count_q + 1;
            if (count_q >= BLOCK_BYTES) begin
              count_q = 0;
              phase_q = PH_CRC;
            end
          end
          PH_CRC: begin
            if (count_q == 0) begin
              count_q = 1;
            end else begin
              count_q = 0;
              phase_q = PH_FINAL;
            end
          end
          PH_FINAL: begin
            if (b == FILL_BYTE) begin
              r.send_valid = 1'b0;
              r.tx_byte    = '0;
              r.done       = 1'b1;
              phase_q      = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    endcase
    r.busy = (phase_q != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    card_step_t got;
    card_step_t want;
    if (!rst_ni) begin
      expected_steps.delete();
      phase_q     = PH_IDLE;
      count_q     = 0;
      address_q   = '0;
      is_write_q  = 1'b0;
      byte_addr_q = 1'b0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) byte_addr_q = cfg_wdata_i;

      // Each output word is registered after its input word is taken, so the oldest
      // expectation is taken before this edge's input word is added.
      if (out_valid_i && !out_stall_i) begin
        got = {send_valid_i, tx_byte_i, read_valid_i, read_byte_i, read_index_i,
               done_res_i, status_i, error_reply_i, busy_res_i};
        checked_o++;
        if (expected_steps.size() == 0) begin
          $error("output word with no expectation waiting: tx_byte %0h busy %0b",
                 tx_byte_i, busy_res_i);
          fail_count_o++;
        end else begin
          want = expected_steps.pop_front();
          check_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
          check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
          check_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
          check_field("read_index", 32'(want.read_index), 32'(got.read_index));
          check_field("done_res", 32'(want.done), 32'(got.done));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("error_reply", 32'(want.error_reply), 32'(got.error_reply));
          check_field("busy_res", 32'(want.busy), 32'(got.busy));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        expected_steps.push_back(advance_sequencer(func_e'(func_i), block_number_i,
                                                   load_index_i, byte_in_i));
      end
      pending_o = expected_steps.size();
    end
  end

endmodule

@@ tb/tb_sd_spi_single_block_rw_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD SPI single block sequencer testbench
// Plays the card side of CMD17 reads and CMD24 writes: a short directed run
// over idle replies, ignored words and command errors, a full buffer load,
// then random reads, writes, rejections and command errors with random
// busy waits, input gaps and output stalls. A checker module does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_sd_spi_single_block_rw_unit;
  import sdspi_pkg::*;

  localparam int unsigned BLOCK_BYTES = DEFAULT_BLOCK_BYTES;
  localparam int HALF_PERIOD_NS = 2;
  localparam int IDLE_PERCENT   = 14;
  localparam int TOTAL_WORDS    = 1550;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_wdata_i    = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [1:0]  func_i         = '0;
  logic [31:0] block_number_i = '0;
  logic [8:0]  load_index_i   = '0;
  logic [7:0]  byte_in_i      = '0;
  logic        out_stall_i    = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        send_valid_o;
  logic [7:0]  tx_byte_o;
  logic        read_valid_o;
  logic [7:0]  read_byte_o;
  logic [8:0]  read_index_o;
  logic        done_res_o;
  logic [1:0]  status_o;
  logic [7:0]  error_reply_o;
  logic        busy_res_o;

  int fail_count;
  int pending_words;
  int checked_words;
  int useful_words  = 0;
  int reads_done    = 0;
  int writes_done   = 0;
  int r1_errors     = 0;
  int rejects       = 0;
  int config_writes = 0;

  always #(HALF_PERIOD_NS) clk_i = ~clk_i;

  sd_spi_single_block_rw_unit #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .block_number_i(block_number_i),
    .load_index_i  (load_index_i),
    .byte_in_i     (byte_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .send_valid_o  (send_valid_o),
    .tx_byte_o     (tx_byte_o),
    .read_valid_o  (read_valid_o),
    .read_byte_o   (read_byte_o),
    .read_index_o  (read_index_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o),
    .error_reply_o (error_reply_o),
    .busy_res_o    (busy_res_o)
  );

  sd_spi_block_checker #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .func_i        (func_i),
    .block_number_i(block_number_i),
    .load_index_i  (load_index_i),
    .byte_in_i     (byte_in_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .send_valid_i  (send_valid_o),
    .tx_byte_i     (tx_byte_o),
    .read_valid_i  (read_valid_o),
    .read_byte_i   (read_byte_o),
    .read_index_i  (read_index_o),
    .done_res_i    (done_res_o),
    .status_i      (status_o),
    .error_reply_i (error_reply_o),
    .busy_res_i    (busy_res_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words),
    .checked_o     (checked_words)
  );

  // A stretch of the random run goes at full rate on both sides.
  function automatic bit quiet_window();
    return useful_words >= 900 && useful_words < 1300;
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= !quiet_window() && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Hang guard.
  initial begin
    #2_000_000;
    $display("tb_sd_spi_single_block_rw_unit: FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next word can follow without a gap.
  task automatic put_word(func_e f, logic [31:0] blk, logic [8:0] idx, logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet_window() && $urandom_range(99) < IDLE_PERCENT) gap = 1;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= f;
    block_number_i <= blk;
    load_index_i   <= idx;
    byte_in_i      <= b;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic hold_off();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    hold_off();
    while (pending_words != 0) @(negedge clk_i);
  endtask

  task automatic set_addressing(logic v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    config_writes++;
  endtask

  task automatic reply_word(logic [7:0] b);
    put_word(FUNC_REPLY, $urandom, 9'($urandom), b);
    useful_words++;
  endtask

  task automatic load_word(logic [8:0] idx, logic [7:0] b);
    put_word(FUNC_LOAD, $urandom, idx, b);
    useful_words++;
  endtask

  task automatic start_word(func_e f, logic [31:0] blk);
    put_word(f, blk, 9'($urandom), 8'($urandom));
    useful_words++;
  endtask

  // Loads and starts sent in the middle of an operation must be ignored.
  task automatic card_reply(logic [7:0] b);
    if ($urandom_range(99) < 3) begin
      if ($urandom_range(1)) put_word(FUNC_LOAD, $urandom, 9'($urandom), 8'($urandom));
      else put_word($urandom_range(1) ? FUNC_READ : FUNC_WRITE, $urandom,
                    9'($urandom), 8'($urandom));
    end
    reply_word(b);
  endtask

  function automatic logic [7:0] other_byte(logic [7:0] avoid);
    logic [7:0] v;
    do v = 8'($urandom); while (v == avoid);
    return v;
  endfunction

  // Mostly short card waits, now and then a long one.
  function automatic int wait_len();
    return ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(2);
  endfunction

  function automatic logic [31:0] pick_block();
    case ($urandom_range(4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h007F_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_operation(logic write, logic r1_fails, logic dresp_fails);
    logic [7:0] b;
    start_word(write ? FUNC_WRITE : FUNC_READ, pick_block());
    repeat (wait_len()) card_reply(other_byte(FILL_BYTE));
    card_reply(FILL_BYTE);
    // The card's answers while the command goes out carry no meaning.
    repeat (6) card_reply(8'($urandom));
    repeat (wait_len()) card_reply(FILL_BYTE);
    if (r1_fails) begin
      do b = 8'($urandom); while (b == 8'h00 || b == FILL_BYTE);
      card_reply(b);
      r1_errors++;
      return;
    end
    card_reply(8'h00);
    if (write) begin
      card_reply(8'($urandom));
      // One answer per data word plus the one that moves on to the response.
      repeat (BLOCK_BYTES + 1) card_reply(8'($urandom));
      repeat (wait_len()) card_reply(FILL_BYTE);
      if (dresp_fails) begin
        do b = 8'($urandom); while (b == FILL_BYTE || (b & DRESP_MASK) == DRESP_OK);
        card_reply(b);
        rejects++;
        return;
      end
      card_reply((8'($urandom) & ~DRESP_MASK) | DRESP_OK);
    end else begin
      repeat (wait_len()) card_reply(other_byte(DATA_TOKEN));
      card_reply(DATA_TOKEN);
      repeat (BLOCK_BYTES + 2) card_reply(8'($urandom));
    end
    repeat (wait_len()) card_reply(other_byte(FILL_BYTE));
    card_reply(FILL_BYTE);
    if (write) writes_done++;
    else reads_done++;
  endtask

  task automatic idle_chaff();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(1)) reply_word(8'($urandom));
      else load_word(9'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int stop_at;
    int long_ops;
    int waited;
    long_ops = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: idle replies, buffer ends, ignored words, command errors.
    reply_word(8'h00);
    reply_word(FILL_BYTE);
    load_word(9'd0, 8'h00);
    load_word(9'd511, 8'hFF);
    start_word(FUNC_READ, 32'hFFFF_FFFF);
    reply_word(8'h00);
    reply_word(FILL_BYTE);
    put_word(FUNC_WRITE, 32'h0000_0000, 9'd0, 8'h00);
    put_word(FUNC_LOAD, 32'h0000_0000, 9'd5, 8'hA5);
    repeat (7) reply_word(FILL_BYTE);
    reply_word(8'h80);
    r1_errors++;
    set_addressing(1'b1);
    start_word(FUNC_WRITE, 32'hFFFF_FFFF);
    reply_word(FILL_BYTE);
    repeat (6) reply_word(8'h00);
    reply_word(8'hFE);
    r1_errors++;

    // Every buffer entry is defined before any write reaches its data.
    for (int i = 0; i < BLOCK_BYTES; i++) load_word(9'(i), 8'($urandom));

    // The last operation runs past the mark by about half a block on average.
    stop_at = TOTAL_WORDS - int'(BLOCK_BYTES) / 2;
    while (useful_words < stop_at) begin
      if (!quiet_window() && $urandom_range(99) < 15) set_addressing(1'($urandom_range(1)));
      case ($urandom_range(9))
        0, 1: idle_chaff();
        2, 3, 4: run_operation(1'($urandom_range(1)), 1'b1, 1'b0);
        default: begin
          case (long_ops % 3)
            0: run_operation(1'b1, 1'b0, 1'b0);
            1: run_operation(1'b0, 1'b0, 1'b0);
            default: run_operation(1'b1, 1'b0, 1'b1);
          endcase
          long_ops++;
        end
      endcase
    end

    hold_off();
    waited = 0;
    while (pending_words != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
    if (pending_words != 0) $error("%0d expected output words never arrived", pending_words);

    $display("Run covered %0d words: %0d reads and %0d writes completed, %0d R1 errors,",
             useful_words, reads_done, writes_done, r1_errors);
    $display("%0d rejected writes, %0d addressing mode writes, %0d output words checked.",
             rejects, config_writes, checked_words);
    if (fail_count == 0 && pending_words == 0) begin
      $display("tb_sd_spi_single_block_rw_unit: PASS");
    end else begin
      $display("tb_sd_spi_single_block_rw_unit: FAIL");
    end
    $finish;
  end

endmodule

@@ sd_spi_single_block_rw_unit.f @@
hdl/sdspi_pkg.sv
hdl/sdspi_ram.sv
hdl/sd_spi_single_block_rw_unit.sv
hdl/sdspi_checker.sv
tb/sd_spi_block_checker.sv
tb/tb_sd_spi_single_block_rw_unit.sv
